FILE: rtl/core/etfi_pkg.sv
// shared types and constants of the escape-time fractal iterator
package etfi_pkg;

  // fixed widths of the channel and configuration fields
  localparam int POINT_BITS    = 32;
  localparam int RESULT_BITS   = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;

  // number of iteration cells in the ring
  localparam int NUM_CELLS = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRACTAL_MODE   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_ITERATIONS = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_JULIA_C_REAL   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_JULIA_C_IMAG   = 2'd3;

  // fractal modes
  localparam logic MODE_MANDELBROT = 1'b0;
  localparam logic MODE_JULIA      = 1'b1;

  // reset values of the configuration registers
  localparam logic [RESULT_BITS-1:0]   MAX_ITER_RESET = 16'd20;
  localparam logic [POINT_BITS-1:0]    JULIA_CR_RESET = 32'd76503203;
  localparam logic [POINT_BITS-1:0]    JULIA_CI_RESET = 32'd2684355;

  // control that travels with a point from cell to cell
  typedef struct packed {
    logic valid;
    logic done;
    logic escaped;
  } cell_ctrl_t;

endpackage

FILE: rtl/core/etfi_if.sv
// request channels of the escape-time fractal iterator

interface etfi_point_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [etfi_pkg::POINT_BITS-1:0] point_real;
  logic signed [etfi_pkg::POINT_BITS-1:0] point_imag;

  modport source (output valid, output point_real, output point_imag, input ready);
  modport sink   (input valid, input point_real, input point_imag, output ready);
endinterface

interface etfi_result_if;
  logic                             valid;
  logic                             ready;
  logic [etfi_pkg::RESULT_BITS-1:0] iteration_count;
  logic                             did_escape;

  modport source (output valid, output iteration_count, output did_escape, input ready);
  modport sink   (input valid, input iteration_count, input did_escape, output ready);
endinterface

FILE: rtl/core/etfi_cell.sv
// one iteration cell: product stage, then escape test and update stage
module etfi_cell #(
  parameter int WORD_BITS  = 32,
  parameter int FRAC_BITS  = 28,
  parameter int COUNT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [COUNT_BITS-1:0]         limit,
  input  etfi_pkg::cell_ctrl_t          in_ctrl,
  input  logic signed [WORD_BITS-1:0]   in_zr,
  input  logic signed [WORD_BITS-1:0]   in_zi,
  input  logic signed [WORD_BITS-1:0]   in_cr,
  input  logic signed [WORD_BITS-1:0]   in_ci,
  input  logic [COUNT_BITS-1:0]         in_cnt,
  output etfi_pkg::cell_ctrl_t          out_ctrl,
  output logic signed [WORD_BITS-1:0]   out_zr,
  output logic signed [WORD_BITS-1:0]   out_zi,
  output logic signed [WORD_BITS-1:0]   out_cr,
  output logic signed [WORD_BITS-1:0]   out_ci,
  output logic [COUNT_BITS-1:0]         out_cnt
);
  import etfi_pkg::*;

  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int MAG_BITS  = (2 * WORD_BITS + 1 > 2 * FRAC_BITS + 3) ?
                             2 * WORD_BITS + 1 : 2 * FRAC_BITS + 3;
  localparam logic [MAG_BITS-1:0] ESC_LIMIT =
    {{(MAG_BITS-1){1'b0}}, 1'b1} << (2 * FRAC_BITS + 2);

  // product stage
  logic                          s1_valid_r;
  logic signed [PROD_BITS-1:0]   s1_prr_r, s1_pii_r, s1_pri_r;
  logic signed [WORD_BITS-1:0]   s1_cr_r, s1_ci_r;
  logic [COUNT_BITS-1:0]         s1_cnt_r;
  logic                          s1_valid_nxt;

  // update stage
  cell_ctrl_t                    ctrl_r, ctrl_nxt;
  logic signed [WORD_BITS-1:0]   zr_r, zi_r, zr_nxt, zi_nxt;
  logic signed [WORD_BITS-1:0]   cr_r, ci_r;
  logic [COUNT_BITS-1:0]         cnt_r, cnt_nxt;

  logic [MAG_BITS-1:0]           mag;
  logic signed [PROD_BITS-1:0]   diff;
  logic                          esc;

  // finished points leave the ring here
  assign s1_valid_nxt = in_ctrl.valid & ~in_ctrl.done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_prr_r <= PROD_BITS'(in_zr) * PROD_BITS'(in_zr);
    s1_pii_r <= PROD_BITS'(in_zi) * PROD_BITS'(in_zi);
    s1_pri_r <= PROD_BITS'(in_zr) * PROD_BITS'(in_zi);
    s1_cr_r  <= in_cr;
    s1_ci_r  <= in_ci;
    s1_cnt_r <= in_cnt;
  end

  // squares are never negative, so the magnitude sum is taken unsigned
  assign mag  = MAG_BITS'($unsigned(s1_prr_r)) + MAG_BITS'($unsigned(s1_pii_r));
  assign esc  = (mag >= ESC_LIMIT);
  assign diff = s1_prr_r - s1_pii_r;

  always_comb begin
    ctrl_nxt.valid   = s1_valid_r;
    ctrl_nxt.done    = 1'b0;
    ctrl_nxt.escaped = 1'b0;
    zr_nxt  = WORD_BITS'(diff >>> FRAC_BITS) + s1_cr_r;
    zi_nxt  = WORD_BITS'(s1_pri_r >>> (FRAC_BITS - 1)) + s1_ci_r;
    cnt_nxt = s1_cnt_r;
    if (esc) begin
      ctrl_nxt.done    = 1'b1;
      ctrl_nxt.escaped = 1'b1;
    end else if (s1_cnt_r >= limit) begin
      ctrl_nxt.done    = 1'b1;
    end else begin
      cnt_nxt = s1_cnt_r + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else begin
      ctrl_r <= ctrl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    zr_r  <= zr_nxt;
    zi_r  <= zi_nxt;
    cr_r  <= s1_cr_r;
    ci_r  <= s1_ci_r;
    cnt_r <= cnt_nxt;
  end

  assign out_ctrl = ctrl_r;
  assign out_zr   = zr_r;
  assign out_zi   = zi_r;
  assign out_cr   = cr_r;
  assign out_ci   = ci_r;
  assign out_cnt  = cnt_r;

endmodule

FILE: rtl/core/escape_time_fractal_iterator_top.sv
// top level of the escape-time fractal iterator: config, cell ring, result buffer
//
//  channel     role    signals
//  in_point    sink    valid/ready, point_real, point_imag (signed Q4.28)
//  out_result  source  valid/ready, iteration_count, did_escape
//  cfg         write   cfg_we, cfg_index, cfg_wdata
//
// a point circulates through a ring of iteration cells, each of them holding
// a multiply stage, then an escape test and update stage; one update per cell
// only one point is in the ring at a time: the next request is taken once the
// point has finished and no result waits in the second slot
// reset is synchronous, clears the ring and both result slots
// a held result does not stop the ring: a second slot takes the next result
module escape_time_fractal_iterator_top #(
  parameter int WORD_BITS  = 32,
  parameter int FRAC_BITS  = 28,
  parameter int COUNT_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  etfi_point_if.sink                            in_point,
  etfi_result_if.source                         out_result,
  input  logic                                  cfg_we,
  input  logic [etfi_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [etfi_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);
  import etfi_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // configuration registers
  logic                     mode_r;
  logic [RESULT_BITS-1:0]   max_iter_r;
  logic [POINT_BITS-1:0]    julia_cr_r, julia_ci_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_MANDELBROT;
      max_iter_r <= MAX_ITER_RESET;
      julia_cr_r <= JULIA_CR_RESET;
      julia_ci_r <= JULIA_CI_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRACTAL_MODE:   mode_r     <= cfg_wdata[0];
        CFG_MAX_ITERATIONS: max_iter_r <= cfg_wdata[RESULT_BITS-1:0];
        CFG_JULIA_C_REAL:   julia_cr_r <= cfg_wdata[POINT_BITS-1:0];
        CFG_JULIA_C_IMAG:   julia_ci_r <= cfg_wdata[POINT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // limit saturates to what the counter can hold
  logic [COUNT_BITS-1:0] limit;
  assign limit = (32'(max_iter_r) > 32'(COUNT_MAX)) ? COUNT_MAX : COUNT_BITS'(max_iter_r);

  // ring links: link 0 feeds the first cell, link NUM_CELLS comes back
  cell_ctrl_t                   link_ctrl [NUM_CELLS+1];
  logic signed [WORD_BITS-1:0]  link_zr   [NUM_CELLS+1];
  logic signed [WORD_BITS-1:0]  link_zi   [NUM_CELLS+1];
  logic signed [WORD_BITS-1:0]  link_cr   [NUM_CELLS+1];
  logic signed [WORD_BITS-1:0]  link_ci   [NUM_CELLS+1];
  logic [COUNT_BITS-1:0]        link_cnt  [NUM_CELLS+1];

  logic                         busy_r, busy_nxt;
  logic                         load;
  logic signed [WORD_BITS-1:0]  pt_re, pt_im, jc_re, jc_im;

  // result slots: output register and one waiting slot
  logic                   out_valid_r, out_valid_nxt;
  logic [RESULT_BITS-1:0] out_cnt_r, out_cnt_nxt;
  logic                   out_esc_r, out_esc_nxt;
  logic                   pend_valid_r, pend_valid_nxt;
  logic [RESULT_BITS-1:0] pend_cnt_r, pend_cnt_nxt;
  logic                   pend_esc_r, pend_esc_nxt;
  logic                   out_free;

  assign in_point.ready = ~busy_r & ~pend_valid_r;
  assign load           = in_point.valid & in_point.ready;

  assign pt_re = WORD_BITS'(in_point.point_real);
  assign pt_im = WORD_BITS'(in_point.point_imag);
  assign jc_re = WORD_BITS'($signed(julia_cr_r));
  assign jc_im = WORD_BITS'($signed(julia_ci_r));

  always_comb begin
    if (load) begin
      link_ctrl[0] = '{valid: 1'b1, done: 1'b0, escaped: 1'b0};
      link_cnt[0]  = '0;
      if (mode_r == MODE_JULIA) begin
        link_zr[0] = pt_re;
        link_zi[0] = pt_im;
        link_cr[0] = jc_re;
        link_ci[0] = jc_im;
      end else begin
        link_zr[0] = '0;
        link_zi[0] = '0;
        link_cr[0] = pt_re;
        link_ci[0] = pt_im;
      end
    end else begin
      link_ctrl[0] = link_ctrl[NUM_CELLS];
      link_zr[0]   = link_zr[NUM_CELLS];
      link_zi[0]   = link_zi[NUM_CELLS];
      link_cr[0]   = link_cr[NUM_CELLS];
      link_ci[0]   = link_ci[NUM_CELLS];
      link_cnt[0]  = link_cnt[NUM_CELLS];
    end
  end

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    etfi_cell #(
      .WORD_BITS  (WORD_BITS),
      .FRAC_BITS  (FRAC_BITS),
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .limit    (limit),
      .in_ctrl  (link_ctrl[g]),
      .in_zr    (link_zr[g]),
      .in_zi    (link_zi[g]),
      .in_cr    (link_cr[g]),
      .in_ci    (link_ci[g]),
      .in_cnt   (link_cnt[g]),
      .out_ctrl (link_ctrl[g+1]),
      .out_zr   (link_zr[g+1]),
      .out_zi   (link_zi[g+1]),
      .out_cr   (link_cr[g+1]),
      .out_ci   (link_ci[g+1]),
      .out_cnt  (link_cnt[g+1])
    );
  end

  // only one point is in the ring, so the finishing cell is picked by or-ing
  logic                   fin;
  logic [RESULT_BITS-1:0] fin_cnt;
  logic                   fin_esc;

  always_comb begin
    fin     = 1'b0;
    fin_cnt = '0;
    fin_esc = 1'b0;
    for (int i = 1; i <= NUM_CELLS; i++) begin
      if (link_ctrl[i].valid && link_ctrl[i].done) begin
        fin     = 1'b1;
        fin_cnt = fin_cnt | RESULT_BITS'(link_cnt[i]);
        fin_esc = fin_esc | link_ctrl[i].escaped;
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (fin) begin
      busy_nxt = 1'b0;
    end
    if (load) begin
      busy_nxt = 1'b1;
    end
  end

  assign out_free = ~out_valid_r | out_result.ready;

  always_comb begin
    out_valid_nxt  = out_valid_r & ~out_result.ready;
    out_cnt_nxt    = out_cnt_r;
    out_esc_nxt    = out_esc_r;
    pend_valid_nxt = pend_valid_r;
    pend_cnt_nxt   = pend_cnt_r;
    pend_esc_nxt   = pend_esc_r;
    if (fin) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_cnt_nxt   = fin_cnt;
        out_esc_nxt   = fin_esc;
      end else begin
        pend_valid_nxt = 1'b1;
        pend_cnt_nxt   = fin_cnt;
        pend_esc_nxt   = fin_esc;
      end
    end else if (pend_valid_r && out_free) begin
      out_valid_nxt  = 1'b1;
      out_cnt_nxt    = pend_cnt_r;
      out_esc_nxt    = pend_esc_r;
      pend_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_cnt_r  <= out_cnt_nxt;
    out_esc_r  <= out_esc_nxt;
    pend_cnt_r <= pend_cnt_nxt;
    pend_esc_r <= pend_esc_nxt;
  end

  assign out_result.valid           = out_valid_r;
  assign out_result.iteration_count = out_cnt_r;
  assign out_result.did_escape      = out_esc_r;

endmodule

FILE: rtl/core/etfi_checker.sv
// port-level checks of the escape-time fractal iterator and their bind
module etfi_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [etfi_pkg::RESULT_BITS-1:0] iteration_count,
  input logic                             did_escape
);
  import etfi_pkg::*;

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(iteration_count) && $stable(did_escape))
    else $error("result changed while held");

  // one point at a time: a taken request blocks the next cycle
  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while a point is in flight");

  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_reset_in: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("not ready after reset");

endmodule

bind escape_time_fractal_iterator_top etfi_checker u_etfi_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_point.valid),
  .in_ready        (in_point.ready),
  .out_valid       (out_result.valid),
  .out_ready       (out_result.ready),
  .iteration_count (out_result.iteration_count),
  .did_escape      (out_result.did_escape)
);
